### design/ufat_pkg.sv
// Shared types and constants for the use-frequency admission table.
package ufat_pkg;

   localparam int ID_W  = 64;
   localparam int CNT_W = 16;
   localparam int CFG_W = 16;

   localparam int DEF_TABLE_ENTRIES = 64;
   localparam int DEF_FRAME_BITS    = 32;

   localparam logic [CFG_W-1:0] OVERDUE_RESET   = 16'd60;
   localparam logic [CFG_W-1:0] THRESHOLD_RESET = 16'd3;
   localparam logic [CNT_W-1:0] COUNT_MAX       = 16'hFFFF;

   typedef enum logic [1:0] {
      CMD_MARK  = 2'd0,
      CMD_TICK  = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef enum logic {
      CSR_OVERDUE   = 1'b0,
      CSR_THRESHOLD = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

### design/use_frequency_admission_table.sv
// Top level: use-frequency admission table with aging sweep.
//
//   channel  ports                       handshake
//   request  req_cmd, req_object_id      start, taken when busy is low
//   result   rsp_* (four fields)         rsp_valid, one cycle, no back-pressure
//   config   csr_index, csr_wdata        csr_we, written at once
//
// A mark runs through the accept cycle, one read pass over the entry memory for
// lookup, free-slot search and aging, then the finish step that writes the marked
// entry. Tick, clear and the unused code do their work in the accept cycle. The
// result word appears the cycle after the work ends. Reset clears all valid bits
// at once, so no clearing pass is needed. The result side cannot stall.
module use_frequency_admission_table
   import ufat_pkg::*;
#(
   parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
   parameter int FRAME_BITS    = DEF_FRAME_BITS,
   localparam int LIVE_W       = $clog2(TABLE_ENTRIES + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_cmd,
   input  logic [ID_W-1:0]   req_object_id,
   output logic              rsp_valid,
   output logic              rsp_worth_caching,
   output logic              rsp_newly_tracked,
   output logic              rsp_dropped_full,
   output logic [LIVE_W-1:0] rsp_live_entries,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [CFG_W-1:0]  csr_wdata
);

   localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int ENTRY_W = ID_W + FRAME_BITS + CNT_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   // entry word: {id, stamp frame, hit count}
   logic [ENTRY_W-1:0] mem [TABLE_ENTRIES];
   logic [ENTRY_W-1:0] mem_q_ff;
   logic               mem_re;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   logic [ENTRY_W-1:0] mem_wdata;

   state_type state_ff, state_in;

   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic [LIVE_W-1:0]        live_ff;
   logic [FRAME_BITS-1:0]    frame_now_ff;
   logic [CFG_W-1:0]         overdue_ff;
   logic [CFG_W-1:0]         threshold_ff;
   logic [ID_W-1:0]          id_ff;

   logic [IDX_W-1:0] addr_ff;
   logic             issuing_ff;
   logic             rd_pend_ff;
   logic [IDX_W-1:0] rd_idx_ff;

   logic             hit_ff;
   logic [IDX_W-1:0] hit_slot_ff;
   logic [CNT_W-1:0] hit_cnt_ff;
   logic             free_ff;
   logic [IDX_W-1:0] free_slot_ff;

   logic              rsp_valid_ff;
   logic              worth_ff;
   logic              newly_ff;
   logic              dropped_ff;

   logic                  accept;
   logic [ID_W-1:0]       q_id;
   logic [FRAME_BITS-1:0] q_frame;
   logic [CNT_W-1:0]      q_cnt;
   logic [FRAME_BITS-1:0] q_age;
   logic                  q_valid;
   logic                  q_expired;
   logic                  keep;
   logic                  placed;
   logic [CNT_W-1:0]      new_cnt;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   assign q_id      = mem_q_ff[ENTRY_W-1 -: ID_W];
   assign q_frame   = mem_q_ff[CNT_W +: FRAME_BITS];
   assign q_cnt     = mem_q_ff[CNT_W-1:0];
   assign q_age     = frame_now_ff - q_frame;
   assign q_valid   = valid_ff[rd_idx_ff];
   assign q_expired = (q_age >= FRAME_BITS'(overdue_ff));

   assign keep    = (overdue_ff != '0);
   assign placed  = hit_ff || free_ff;
   assign new_cnt = !hit_ff ? CNT_W'(1)
                  : (hit_cnt_ff == COUNT_MAX) ? hit_cnt_ff : hit_cnt_ff + CNT_W'(1);

   assign mem_re    = (state_ff == ST_SCAN) && issuing_ff;
   assign mem_we    = (state_ff == ST_FINISH) && placed;
   assign mem_waddr = hit_ff ? hit_slot_ff : free_slot_ff;
   assign mem_wdata = {id_ff, frame_now_ff, new_cnt};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_q_ff <= mem[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_cmd == CMD_MARK)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_pend_ff && (rd_idx_ff == LAST_IDX)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         live_ff      <= '0;
         frame_now_ff <= '0;
         overdue_ff   <= OVERDUE_RESET;
         threshold_ff <= THRESHOLD_RESET;
         issuing_ff   <= 1'b0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_we) begin
            case (csr_index)
               CSR_OVERDUE:   overdue_ff   <= csr_wdata;
               CSR_THRESHOLD: threshold_ff <= csr_wdata;
               default:       ;
            endcase
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  worth_ff   <= 1'b0;
                  newly_ff   <= 1'b0;
                  dropped_ff <= 1'b0;
                  case (req_cmd)
                     CMD_MARK: begin
                        id_ff      <= req_object_id;
                        addr_ff    <= '0;
                        issuing_ff <= 1'b1;
                        hit_ff     <= 1'b0;
                        free_ff    <= 1'b0;
                     end
                     CMD_TICK: begin
                        frame_now_ff <= frame_now_ff + FRAME_BITS'(1);
                        rsp_valid_ff <= 1'b1;
                     end
                     CMD_CLEAR: begin
                        valid_ff     <= '0;
                        live_ff      <= '0;
                        rsp_valid_ff <= 1'b1;
                     end
                     default: rsp_valid_ff <= 1'b1;
                  endcase
               end
            end
            ST_SCAN: begin
               rd_pend_ff <= issuing_ff;
               rd_idx_ff  <= addr_ff;
               if (issuing_ff) begin
                  if (addr_ff == LAST_IDX) begin
                     issuing_ff <= 1'b0;
                  end else begin
                     addr_ff <= addr_ff + IDX_W'(1);
                  end
               end
               // the hit entry is restamped, so age it in the finish step instead
               if (rd_pend_ff) begin
                  if (q_valid) begin
                     if (!hit_ff && (q_id == id_ff)) begin
                        hit_ff      <= 1'b1;
                        hit_slot_ff <= rd_idx_ff;
                        hit_cnt_ff  <= q_cnt;
                     end else if (q_expired) begin
                        valid_ff[rd_idx_ff] <= 1'b0;
                        live_ff             <= live_ff - LIVE_W'(1);
                     end
                  end else if (!free_ff) begin
                     free_ff      <= 1'b1;
                     free_slot_ff <= rd_idx_ff;
                  end
               end
            end
            ST_FINISH: begin
               rd_pend_ff   <= 1'b0;
               rsp_valid_ff <= 1'b1;
               newly_ff     <= !hit_ff && free_ff;
               dropped_ff   <= !hit_ff && !free_ff;
               worth_ff     <= placed && keep && (new_cnt >= threshold_ff);
               // a zero overdue age sweeps out the marked entry too
               if (hit_ff && !keep) begin
                  valid_ff[hit_slot_ff] <= 1'b0;
                  live_ff               <= live_ff - LIVE_W'(1);
               end else if (!hit_ff && free_ff && keep) begin
                  valid_ff[free_slot_ff] <= 1'b1;
                  live_ff                <= live_ff + LIVE_W'(1);
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_worth_caching = worth_ff;
   assign rsp_newly_tracked = newly_ff;
   assign rsp_dropped_full  = dropped_ff;
   assign rsp_live_entries  = live_ff;

endmodule
